/* rtl/tisq_pkg.sv */
// Package for the triangular test by integer square root.
// Holds field widths, stream widths and the default data path width.
// Used by the top level and by its checker.
`default_nettype none

package tisq_pkg;

  // Default width of d = 8m+1 in the square-root data path
  localparam int DATA_WIDTH_DEF = 64;

  // Field widths
  localparam int CAND_W = 61;
  localparam int ROOT_W = 32;
  localparam int TRI_W  = 32;

  // Stream widths, packed fields rounded up to whole bytes
  localparam int IN_TDATA_W  = ((CAND_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = ROOT_W + 1 + 1 + TRI_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Bit positions of the result fields in the output tdata
  localparam int OUT_SQ_POS  = ROOT_W;
  localparam int OUT_ADM_POS = ROOT_W + 1;
  localparam int OUT_TRI_LO  = ROOT_W + 2;

endpackage

`default_nettype wire

/* rtl/triangular_test_by_isqrt.sv */
// Stages from input transfer to result:
// one stage forms d = 8m+1, one stage per two-bit root step, one output stage.
// Throughput: one item per cycle while the output is not stalled; each stage holds one item and moves on when the
// stage after it is empty or moving, so bubbles close up under output stalls.
// Reset clears all valid bits; payload registers are not reset.
// Depends on tisq_pkg.
`default_nettype none

module triangular_test_by_isqrt
  import tisq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [60:0] candidate, rest ignored
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // [31:0] root, [32] is_square,
                                                      // [33] admissible,
                                                      // [65:34] tri_index, rest zero
);

  localparam int STEPS = (DATA_WIDTH - 1) / 2 + 1;  // two-bit root steps
  localparam int TOP   = ((DATA_WIDTH - 1) / 2) * 2; // position of first trial bit
  localparam int LAST  = STEPS + 1;                  // index of the output stage

  // Per-stage registers: stage 0 holds d, stage k holds state after step k
  logic                  valid [0:LAST];
  logic                  ready [0:LAST+1];
  logic [DATA_WIDTH-1:0] rem   [0:STEPS];
  logic [DATA_WIDTH-1:0] root  [0:STEPS];
  logic                  nz    [0:STEPS];

  // Output stage registers
  logic [ROOT_W-1:0] root_out;
  logic              sq_out;
  logic              adm_out;
  logic [TRI_W-1:0]  tri_out;

  // Stage input signals
  logic [63:0]       d_full;
  logic [ROOT_W-1:0] root_fin;
  logic [ROOT_W:0]   root_inc;

  // Stall chain: a stage can load when it is empty or the next one takes its item
  always_comb begin
    ready[LAST+1] = m_axis_tready;
    for (int i = LAST; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign s_axis_tready = ready[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      if (ready[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i <= LAST; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Stage 0: form d = 8m+1 at the data path width
  assign d_full = {s_axis_tdata[CAND_W-1:0], 3'b000} + 64'd1;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      rem[0]  <= d_full[DATA_WIDTH-1:0];
      root[0] <= '0;
      nz[0]   <= |s_axis_tdata[CAND_W-1:0];
    end
  end

  // Root stages: one trial subtract and compare each
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam logic [DATA_WIDTH-1:0] BIT = DATA_WIDTH'(1) << (TOP - 2 * (k - 1));

    logic [DATA_WIDTH-1:0] trial;
    logic                  take;

    assign trial = root[k-1] + BIT;
    assign take  = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (ready[k]) begin
        nz[k] <= nz[k-1];
        if (take) begin
          rem[k]  <= rem[k-1] - trial;
          root[k] <= (root[k-1] >> 1) + BIT;
        end else begin
          rem[k]  <= rem[k-1];
          root[k] <= root[k-1] >> 1;
        end
      end
    end
  end

  // Output stage: flags and triangular index
  assign root_fin = ROOT_W'(root[STEPS]);
  assign root_inc = {1'b0, root_fin} + (ROOT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (ready[LAST]) begin
      root_out <= root_fin;
      sq_out   <= rem[STEPS] == '0;
      adm_out  <= (rem[STEPS] == '0) && nz[STEPS];
      tri_out  <= root_inc[ROOT_W:1];
    end
  end

  // Pack the result transfer
  assign m_axis_tvalid = valid[LAST];
  always_comb begin
    m_axis_tdata                                 = '0;
    m_axis_tdata[ROOT_W-1:0]                     = root_out;
    m_axis_tdata[OUT_SQ_POS]                     = sq_out;
    m_axis_tdata[OUT_ADM_POS]                    = adm_out;
    m_axis_tdata[OUT_TRI_LO +: TRI_W]            = tri_out;
  end

endmodule

`default_nettype wire

/* rtl/tisq_checker.sv */
// Port-level checker for triangular_test_by_isqrt, bound to the top level.
// Depends on tisq_pkg.
`default_nettype none

module tisq_assertions
  import tisq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [ROOT_W-1:0] root_f;
  logic              sq_f;
  logic              adm_f;
  logic [TRI_W-1:0]  tri_f;
  logic [ROOT_W:0]   root_inc;

  assign root_f   = m_axis_tdata[ROOT_W-1:0];
  assign sq_f     = m_axis_tdata[OUT_SQ_POS];
  assign adm_f    = m_axis_tdata[OUT_ADM_POS];
  assign tri_f    = m_axis_tdata[OUT_TRI_LO +: TRI_W];
  assign root_inc = {1'b0, root_f} + (ROOT_W+1)'(1);

  // No result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Admissible only for squares
  a_adm: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !adm_f || sq_f)
    else $error("admissible without square");

  // d is odd, so an exact root is odd
  a_odd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && sq_f |-> root_f[0])
    else $error("exact root is even");

  // Index follows the root
  a_tri: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> tri_f == root_inc[ROOT_W:1])
    else $error("tri_index does not match root");

endmodule

bind triangular_test_by_isqrt tisq_assertions u_tisq_assertions (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/sv/tisq_checker.sv */
// Checker for the triangular test by integer square root: watches both streams,
// predicts each result from the input transfer and compares it field by field.
// Depends on tisq_pkg for field widths and result bit positions.

module tisq_checker
  import tisq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [60:0] candidate
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] root, [32] is_square,
                                                      // [33] admissible, [65:34] tri_index
  output int                          fail_count,
  output int                          due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0]       cand;
    logic [ROOT_W-1:0] root;
    logic              is_sq;
    logic              adm;
    logic [TRI_W-1:0]  tri_idx;
  } tisq_result_t;

  // Results predicted for accepted candidates, oldest first
  tisq_result_t isqrt_due_q[$];

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  // Form d = 8m+1 at the data path width and run the restoring root, two bits per step
  function automatic tisq_result_t isqrt_triangular(input logic [IN_TDATA_W-1:0] raw);
    tisq_result_t res;
    logic [63:0]  m;
    logic [63:0]  d;
    logic [63:0]  rem;
    logic [63:0]  acc;
    logic [63:0]  bit_v;
    logic [63:0]  trial;
    logic [63:0]  half;
    m     = 64'(raw[CAND_W-1:0]);
    d     = ((m << 3) + 64'd1) & ({64{1'b1}} >> (64 - DATA_WIDTH));
    rem   = d;
    acc   = '0;
    bit_v = 64'd1 << (((DATA_WIDTH - 1) / 2) * 2);
    while (bit_v != 0) begin
      trial = acc + bit_v;
      if (rem >= trial) begin
        rem = rem - trial;
        acc = (acc >> 1) + bit_v;
      end else begin
        acc = acc >> 1;
      end
      bit_v = bit_v >> 2;
    end
    half        = (acc + 64'd1) >> 1;
    res.cand    = 64'(raw);
    res.root    = acc[ROOT_W-1:0];
    res.is_sq   = (rem == 0);
    res.adm     = res.is_sq && (m != 0);
    res.tri_idx = half[TRI_W-1:0];
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what, input logic [63:0] cand,
                               input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s wrong for candidate %h: got %h, want %h", $realtime, what, cand,
             got, want);
    fail_count = fail_count + 1;
  endtask

  // Retire results first, then queue the prediction for a new candidate
  always @(posedge clk) begin
    tisq_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (isqrt_due_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, 64'(m_axis_tdata[ROOT_W-1:0]), '0);
        end else begin
          want = isqrt_due_q.pop_front();
          if (m_axis_tdata[ROOT_W-1:0] !== want.root)
            flag_mismatch("root", want.cand, 64'(m_axis_tdata[ROOT_W-1:0]), 64'(want.root));
          if (m_axis_tdata[OUT_SQ_POS] !== want.is_sq)
            flag_mismatch("is_square", want.cand, 64'(m_axis_tdata[OUT_SQ_POS]),
                          64'(want.is_sq));
          if (m_axis_tdata[OUT_ADM_POS] !== want.adm)
            flag_mismatch("admissible", want.cand, 64'(m_axis_tdata[OUT_ADM_POS]),
                          64'(want.adm));
          if (m_axis_tdata[OUT_TRI_LO +: TRI_W] !== want.tri_idx)
            flag_mismatch("tri_index", want.cand, 64'(m_axis_tdata[OUT_TRI_LO +: TRI_W]),
                          64'(want.tri_idx));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        isqrt_due_q.insert(isqrt_due_q.size(), isqrt_triangular(s_axis_tdata));
    end
    due_count <= isqrt_due_q.size();
  end

endmodule

/* tb/sv/triangular_test_by_isqrt_tb.sv */
// Testbench top for the triangular test by integer square root: drives candidates
// with random gaps and back-pressure, and reports the checker's verdict.
// Depends on tisq_pkg, triangular_test_by_isqrt and tisq_checker.

module triangular_test_by_isqrt_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tisq_pkg::*;

  localparam int          LATENCY    = (DATA_WIDTH_DEF - 1) / 2 + 3;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          RAND_ITEMS = 400;
  localparam logic [63:0] CAND_MASK  = (64'd1 << CAND_W) - 64'd1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  wire logic              s_axis_tready;
  wire logic              m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     fail_count;
  int                     due_count;
  logic                   no_idle = 1'b0;
  int                     idle_cycles = 0;
  int                     ready_hold = 0;
  int                     ready_stall;

  // Extremes, small triangular numbers, top of range and stray high bits
  logic [63:0] directed_cands[$] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd10, 64'd36,
    64'd100, 64'd4950,
    64'h1FFF_FFFF_FFFF_FFFF, 64'h1000_0000_0000_0000,
    64'h1FFF_FFFF_C000_0000, 64'h1FFF_FFFF_BFFF_FFFF, 64'h1FFF_FFFF_C000_0001,
    64'h1FFF_FFFF_4000_0001,
    64'h0AAA_AAAA_AAAA_AAAA, 64'h1555_5555_5555_5555,
    64'hE000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2000_0000_0000_0006,
    64'h5FFF_FFFF_C000_0000
  };

  triangular_test_by_isqrt #(
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tisq_checker #(
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .due_count     (due_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall length: mostly none, often short, now and then long
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  // Mostly triangular numbers and their neighbors, plus raw and tiny values
  function automatic logic [63:0] random_candidate();
    int          r;
    int          pick;
    logic [63:0] w;
    logic [63:0] m;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) w = 64'($urandom_range(0, 5000));
      else if (pick < 9) w = 64'($urandom_range(0, 32'h8000_0000));
      else w = 64'(32'h8000_0000 - $urandom_range(0, 100));
      m = (w * (w - 64'd1)) >> 1;
      if (r >= 40) m = m + 64'($urandom_range(0, 4)) - 64'd2;
    end else if (r < 85) begin
      m = {$urandom, $urandom};
    end else begin
      m = 64'($urandom_range(0, 300));
    end
    m = m & CAND_MASK;
    if ($urandom_range(0, 19) == 0) m[63:CAND_W] = 3'($urandom_range(1, 7));
    return m;
  endfunction

  // Offer one candidate after an optional gap and hold it until the transfer
  task automatic push_candidate(input logic [63:0] cand);
    int gap;
    gap = no_idle ? 0 : pick_stall();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cand;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Toggle result back-pressure: stalls of random length between ready stretches
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_axis_tready) begin
      ready_stall = pick_stall();
      if (ready_stall > 0) begin
        m_axis_tready <= 1'b0;
        ready_hold    <= ready_stall - 1;
      end else begin
        ready_hold <= $urandom_range(0, 15);
      end
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold    <= $urandom_range(0, 15);
    end
  end

  // End the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, directed candidates, random candidates, drain and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_cands[i]) push_candidate(directed_cands[i]);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      push_candidate(random_candidate());
    end
    s_axis_tvalid <= 1'b0;
    no_idle       <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
